// ----- sv/bitmap_frame_allocator_core_defines.svh -----
// Assertion macros for the checker file of the frame allocator.
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_DEFINES_SVH

// Concurrent assertion on a clock, switched off while reset is high.
`define BFA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that a condition never holds.
`define BFA_NEVER(lbl, clk, rst, cond, msg) \
   `BFA_ASSERT(lbl, clk, rst, !(cond), msg)

`endif

// ----- sv/bfa_pkg.sv -----
// Shared types and constants of the bitmap frame allocator.
package bfa_pkg;

   // Field widths of the request, response and register.
   localparam int OP_W       = 2;
   localparam int ADDR_W     = 32;
   localparam int RSP_ADDR_W = 27;
   localparam int STATUS_W   = 2;
   localparam int CFG_W      = 16;

   // Reset value of the managed frame count.
   localparam logic [CFG_W-1:0] CFG_RESET = 16'd32768;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;
   localparam logic [OP_W-1:0] OP_RESERVE = 2'd3;

   // Response status codes.
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_write;
      logic accept;
      logic scan_issue;
      logic alloc_write;
      logic rmw_read;
      logic rmw_write;
      logic resp_full;
      logic resp_range;
   } bfa_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last;
      logic op_is_alloc;
      logic hit;
      logic scan_empty;
      logic out_of_range;
   } bfa_sts_type;

endpackage

// ----- sv/bfa_ctrl.sv -----
// Controller state machine of the bitmap frame allocator.
module bfa_ctrl
   import bfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  bfa_sts_type sts,
   output bfa_cmd_type cmd,
   output logic        busy
);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_SCAN   = 3'd2;
   localparam logic [2:0] S_ALLOC  = 3'd3;
   localparam logic [2:0] S_READ   = 3'd4;
   localparam logic [2:0] S_MODIFY = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   // Next state and command decode.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (sts.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = sts.op_is_alloc ? S_SCAN : S_READ;
            end
         end
         S_SCAN: begin
            if (sts.hit) begin
               state_in = S_ALLOC;
            end else if (sts.scan_empty) begin
               cmd.resp_full = 1'b1;
               state_in      = S_IDLE;
            end else begin
               cmd.scan_issue = 1'b1;
            end
         end
         S_ALLOC: begin
            cmd.alloc_write = 1'b1;
            state_in        = S_IDLE;
         end
         S_READ: begin
            if (sts.out_of_range) begin
               cmd.resp_range = 1'b1;
               state_in       = S_IDLE;
            end else begin
               cmd.rmw_read = 1'b1;
               state_in     = S_MODIFY;
            end
         end
         S_MODIFY: begin
            cmd.rmw_write = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register; reset starts the clearing pass.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

// ----- sv/bfa_datapath.sv -----
// Datapath of the bitmap frame allocator: bitmap memory, scan and response registers.
module bfa_datapath
   import bfa_pkg::*;
#(
   parameter int FRAME_LIMIT = 32768,
   parameter int WORD_BITS   = 32,
   parameter int FRAME_BYTES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  bfa_cmd_type           cmd,
   output bfa_sts_type           sts,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_data,
   output logic                  rsp_valid,
   output logic [RSP_ADDR_W-1:0] rsp_frame_address,
   output logic [STATUS_W-1:0]   rsp_status
);

   localparam int FB_LOG     = $clog2(FRAME_BYTES);
   localparam int WB_LOG     = $clog2(WORD_BITS);
   localparam int WORD_COUNT = (FRAME_LIMIT + WORD_BITS - 1) / WORD_BITS;
   localparam int WI_W       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int WC_W       = $clog2(WORD_COUNT + 1);
   localparam int FRM_W      = ADDR_W - FB_LOG;

   // Bitmap storage, one bit per frame, 1 means used.
   logic [WORD_BITS-1:0] mem [WORD_COUNT];

   logic [CFG_W-1:0]     cfg_ff;
   logic [OP_W-1:0]      op_ff;
   logic [FRM_W-1:0]     frame_ff;
   logic [WC_W-1:0]      scan_idx_ff;
   logic [WC_W-1:0]      scan_idx_in;
   logic                 rd_valid_ff;
   logic                 rd_valid_in;
   logic [WI_W-1:0]      chk_idx_ff;
   logic [WORD_BITS-1:0] rdata_ff;
   logic                 rsp_valid_ff;
   logic [RSP_ADDR_W-1:0] rsp_addr_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   logic [31:0]          cfg_ext;
   logic [31:0]          lim_ext;
   logic [31:0]          nwords_ext;
   logic [31:0]          lim_word_ext;
   logic [WB_LOG-1:0]    lim_rem;
   logic                 scan_more;
   logic [WORD_BITS-1:0] valid_mask;
   logic [WORD_BITS-1:0] free_vec;
   logic [WB_LOG-1:0]    hit_idx;
   logic [31:0]          alloc_frame;
   logic [31:0]          alloc_byte;
   logic [31:0]          frame_ext;
   logic [WI_W-1:0]      frame_word;
   logic [WORD_BITS-1:0] frame_bit;
   logic [WORD_BITS-1:0] hit_bit;

   logic                 rd_en;
   logic [WI_W-1:0]      rd_addr;
   logic                 wr_en;
   logic [WI_W-1:0]      wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   // Effective frame count and the words that hold it.
   assign cfg_ext      = 32'(cfg_ff);
   assign lim_ext      = (cfg_ext < 32'(FRAME_LIMIT)) ? cfg_ext : 32'(FRAME_LIMIT);
   assign nwords_ext   = (lim_ext + 32'(WORD_BITS - 1)) >> WB_LOG;
   assign lim_word_ext = lim_ext >> WB_LOG;
   assign lim_rem      = lim_ext[WB_LOG-1:0];
   assign scan_more    = (32'(scan_idx_ff) < nwords_ext);

   // Free bits of the word under test; bits past the count are treated as used.
   assign valid_mask = (32'(chk_idx_ff) == lim_word_ext) ?
                       ((WORD_BITS'(1) << lim_rem) - WORD_BITS'(1)) : '1;
   assign free_vec   = ~rdata_ff & valid_mask;

   // Lowest free bit of the word.
   always_comb begin
      hit_idx = '0;
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (free_vec[j]) begin
            hit_idx = WB_LOG'(j);
         end
      end
   end

   assign hit_bit     = WORD_BITS'(1) << hit_idx;
   assign alloc_frame = (32'(chk_idx_ff) << WB_LOG) | 32'(hit_idx);
   assign alloc_byte  = alloc_frame << FB_LOG;

   // Addressed frame of a free, release or reserve transaction.
   assign frame_ext  = 32'(frame_ff);
   assign frame_word = frame_ext[WB_LOG +: WI_W];
   assign frame_bit  = WORD_BITS'(1) << frame_ext[WB_LOG-1:0];

   // Status to the controller.
   assign sts.clear_last   = (scan_idx_ff == WC_W'(WORD_COUNT - 1));
   assign sts.op_is_alloc  = (req_operation == OP_ALLOC);
   assign sts.hit          = rd_valid_ff && (|free_vec);
   assign sts.scan_empty   = !scan_more && !rd_valid_ff;
   assign sts.out_of_range = (frame_ext >= lim_ext);

   // Memory port selection.
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = frame_word;
      wr_en   = 1'b0;
      wr_addr = frame_word;
      wr_data = rdata_ff & ~frame_bit;
      if (cmd.scan_issue && scan_more) begin
         rd_en   = 1'b1;
         rd_addr = scan_idx_ff[WI_W-1:0];
      end else if (cmd.rmw_read) begin
         rd_en = 1'b1;
      end
      priority if (cmd.clear_write) begin
         wr_en   = 1'b1;
         wr_addr = scan_idx_ff[WI_W-1:0];
         wr_data = '1;
      end else if (cmd.alloc_write) begin
         wr_en   = 1'b1;
         wr_addr = chk_idx_ff;
         wr_data = rdata_ff | hit_bit;
      end else if (cmd.rmw_write) begin
         wr_en   = 1'b1;
         wr_data = (op_ff == OP_RESERVE) ? (rdata_ff | frame_bit) : (rdata_ff & ~frame_bit);
      end else begin
         wr_en = 1'b0;
      end
   end

   // Bitmap memory with registered read.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Scan counter and read-valid flag; the counter also walks the clearing pass.
   always_comb begin
      scan_idx_in = scan_idx_ff;
      rd_valid_in = rd_valid_ff;
      if (cmd.accept) begin
         scan_idx_in = '0;
         rd_valid_in = 1'b0;
      end else if (cmd.clear_write) begin
         scan_idx_in = scan_idx_ff + WC_W'(1);
      end else if (cmd.scan_issue) begin
         rd_valid_in = scan_more;
         if (scan_more) begin
            scan_idx_in = scan_idx_ff + WC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff  <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= CFG_RESET;
      end else begin
         scan_idx_ff  <= scan_idx_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= cmd.alloc_write | cmd.rmw_write | cmd.resp_full | cmd.resp_range;
         if (csr_valid) begin
            cfg_ff <= csr_data;
         end
      end
   end

   // Request capture, checked word index and response payload.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_operation;
         frame_ff <= req_address[ADDR_W-1:FB_LOG];
      end
      if (cmd.scan_issue && scan_more) begin
         chk_idx_ff <= scan_idx_ff[WI_W-1:0];
      end
      if (cmd.resp_full) begin
         rsp_status_ff <= ST_FULL;
      end else if (cmd.resp_range) begin
         rsp_status_ff <= ST_RANGE;
      end else begin
         rsp_status_ff <= ST_OK;
      end
      rsp_addr_ff <= cmd.alloc_write ? alloc_byte[RSP_ADDR_W-1:0] : '0;
   end

   assign csr_ready         = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frame_address = rsp_addr_ff;
   assign rsp_status        = rsp_status_ff;

endmodule

// ----- sv/bitmap_frame_allocator_core.sv -----
// Top level of the first-fit bitmap frame allocator.
//
// After reset the block walks the bitmap once to mark every frame used, one word per
// cycle, and holds busy high while it walks all WORD_COUNT words (1024 by default);
// the frame count register can be written during that time. A transaction is taken
// when start is high and busy is low. Free, release and reserve read-modify-write the
// frame's bitmap word, or only give a range status when the frame is out of range.
// Alloc reads one bitmap word per cycle through the memory's registered read port,
// stops at the first word with a free frame and reports full when no word within the
// frame count has one. Each result shows on the rsp_ ports for one cycle with rsp_valid
// and cannot be held off, and the next transaction can be started in that same cycle.
// The frame count register is written whenever csr_valid is high.
module bitmap_frame_allocator_core
   import bfa_pkg::*;
#(
   parameter int FRAME_LIMIT = 32768,
   parameter int WORD_BITS   = 32,
   parameter int FRAME_BYTES = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [ADDR_W-1:0]     req_address,
   output logic                  rsp_valid,
   output logic [RSP_ADDR_W-1:0] rsp_frame_address,
   output logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_data
);

   bfa_cmd_type cmd;
   bfa_sts_type sts;

   // Sequencing of the clearing pass, scan and read-modify-write.
   bfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   // Bitmap memory, search logic and registers.
   bfa_datapath #(
      .FRAME_LIMIT (FRAME_LIMIT),
      .WORD_BITS   (WORD_BITS),
      .FRAME_BYTES (FRAME_BYTES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_address       (req_address),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_frame_address (rsp_frame_address),
      .rsp_status        (rsp_status)
   );

endmodule

// ----- sv/bfa_checker.sv -----
// Port-level checker of the frame allocator and its bind to the top level.
`include "bitmap_frame_allocator_core_defines.svh"

module bfa_checker
   import bfa_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input logic                  rsp_valid,
   input logic [RSP_ADDR_W-1:0] rsp_frame_address,
   input logic [STATUS_W-1:0]   rsp_status
);

   // A started transaction keeps the block busy in the next cycle.
   `BFA_ASSERT(a_start_busy, clock, reset, (start && !busy) |=> busy, "busy low after a start")

   // Each result is a single-cycle strobe.
   `BFA_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid, "rsp_valid held two cycles")

   // A failed transaction never carries a frame address.
   `BFA_NEVER(a_fail_addr, clock, reset,
      rsp_valid && (rsp_status != ST_OK) && (rsp_frame_address != '0),
      "nonzero frame address on a failed transaction")

   // Status is one of the defined codes.
   `BFA_NEVER(a_status_code, clock, reset,
      rsp_valid && (rsp_status != ST_OK) && (rsp_status != ST_FULL) && (rsp_status != ST_RANGE),
      "undefined response status")

endmodule

bind bitmap_frame_allocator_core bfa_checker u_bfa_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_frame_address (rsp_frame_address),
   .rsp_status        (rsp_status)
);
